// File: design/dap_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper function of the decimal amount parser.
package dap_pkg;

  localparam int unsigned FracDigitsDef = 8;
  localparam int unsigned QueueDepth    = 2;

  localparam int unsigned ChW     = 8;
  localparam int unsigned AmountW = 64;
  localparam int unsigned StatusW = 3;
  localparam int unsigned WholeW  = 63;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NumDig  = 10;

  localparam logic [AmountW-1:0] MagMax = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [ChW-1:0] CharDot   = 8'h2E;
  localparam logic [ChW-1:0] CharMinus = 8'h2D;
  localparam logic [ChW-1:0] CharPlus  = 8'h2B;
  localparam logic [ChW-1:0] CharZero  = 8'h30;
  localparam logic [ChW-1:0] CharNine  = 8'h39;

  typedef enum logic [StatusW-1:0] {
    ST_OK           = 3'd0,
    ST_BAD_CHAR     = 3'd1,
    ST_SECOND_DOT   = 3'd2,
    ST_TOO_MANY_DEC = 3'd3,
    ST_RANGE        = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    KIND_DIGIT,
    KIND_DOT,
    KIND_PLUS,
    KIND_MINUS,
    KIND_BAD
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [DigitW-1:0] digit;
    logic              last;
  } item_t;

  typedef struct packed {
    logic              neg;
    status_e           status;
    logic [WholeW-1:0] whole;
    logic [WholeW-1:0] frac;
  } total_t;

  // Power of ten, saturating at 10^19; evaluated at elaboration only.
  function automatic logic [AmountW-1:0] pow10(input int unsigned n);
    logic [AmountW-1:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < 19; i++) begin
      if (i < n) begin
        p = p * 64'd10;
      end
    end
    return p;
  endfunction

endpackage

// File: design/dap_classify.sv
`timescale 1ns / 1ps
// Front stage: registers each character beat and classifies it.
module dap_classify (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [dap_pkg::ChW-1:0]  ch_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output dap_pkg::item_t           item_o
);
  import dap_pkg::*;

  logic  vld_q;
  logic  first_q;
  item_t item_q;
  item_t item_d;

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign item_o      = item_q;

  always_comb begin
    item_d.digit = DigitW'(ch_i - CharZero);
    item_d.last  = last_i;
    if (ch_i >= CharZero && ch_i <= CharNine) begin
      item_d.kind = KIND_DIGIT;
    end else if (ch_i == CharDot) begin
      item_d.kind = KIND_DOT;
    end else if (first_q && ch_i == CharPlus) begin
      item_d.kind = KIND_PLUS;
    end else if (first_q && ch_i == CharMinus) begin
      item_d.kind = KIND_MINUS;
    end else begin
      item_d.kind = KIND_BAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      first_q <= 1'b1;
    end else begin
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
      if (in_valid_i && in_ready_o) begin
        first_q <= last_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

// File: design/dap_queue.sv
`timescale 1ns / 1ps
// Short queue of classified characters between the front and back stages.
module dap_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dap_pkg::item_t item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dap_pkg::item_t item_o
);
  import dap_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push;
  logic            pop;

  assign in_ready_o  = cnt_q != CntW'(QueueDepth);
  assign out_valid_o = cnt_q != '0;
  assign item_o      = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: design/dap_accum.sv
`timescale 1ns / 1ps
// Back stage: accumulates the scaled whole and fraction parts and tracks scan errors.
module dap_accum #(
  parameter int unsigned FRAC_DIGITS = dap_pkg::FracDigitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dap_pkg::item_t  item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dap_pkg::total_t total_o
);
  import dap_pkg::*;

  localparam logic [AmountW-1:0] Scale = pow10(FRAC_DIGITS);
  localparam int unsigned FracW = $clog2(Scale);
  localparam int unsigned CntW  = $clog2(FRAC_DIGITS + 2);
  localparam int unsigned IdxW  = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
  localparam int unsigned NextW = WholeW + 5;
  localparam logic [AmountW-1:0] LimitScaled = (MagMax / Scale) * Scale;

  logic [AmountW-1:0] whole_wt [NumDig];
  logic [FracW-1:0]   frac_wt  [FRAC_DIGITS][NumDig];

  for (genvar d = 0; d < NumDig; d++) begin : g_whole_wt
    assign whole_wt[d] = AmountW'(Scale * 64'(d));
    for (genvar i = 0; i < FRAC_DIGITS; i++) begin : g_frac_wt
      assign frac_wt[i][d] = FracW'(pow10(FRAC_DIGITS - 1 - i) * 64'(d));
    end
  end

  logic              neg_q, neg_d;
  logic              dot_q, dot_d;
  logic              ovf_q, ovf_d;
  logic [WholeW-1:0] whole_q, whole_d;
  logic [FracW-1:0]  frac_q, frac_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  status_e           err_q, err_d;
  logic [NextW-1:0]  whole_next;
  logic              tot_vld_q;
  total_t            tot_q;
  total_t            tot_d;
  logic              pop;
  logic              tot_load;

  assign in_ready_o  = !item_i.last || !tot_vld_q || out_ready_i;
  assign pop         = in_valid_i && in_ready_o;
  assign tot_load    = pop && item_i.last;
  assign out_valid_o = tot_vld_q;
  assign total_o     = tot_q;

  assign whole_next = (NextW'(whole_q) << 3) + (NextW'(whole_q) << 1)
                    + NextW'(whole_wt[item_i.digit]);

  always_comb begin
    neg_d   = neg_q;
    dot_d   = dot_q;
    ovf_d   = ovf_q;
    whole_d = whole_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    if (err_q == ST_OK) begin
      case (item_i.kind)
        KIND_PLUS:  neg_d = 1'b0;
        KIND_MINUS: neg_d = 1'b1;
        KIND_DOT: begin
          if (dot_q) begin
            err_d = ST_SECOND_DOT;
          end else begin
            dot_d = 1'b1;
          end
        end
        KIND_DIGIT: begin
          if (dot_q) begin
            if (cnt_q < CntW'(FRAC_DIGITS)) begin
              frac_d = frac_q + frac_wt[cnt_q[IdxW-1:0]][item_i.digit];
              cnt_d  = cnt_q + 1'b1;
            end else begin
              cnt_d = CntW'(FRAC_DIGITS + 1);
            end
          end else if (!ovf_q) begin
            if (whole_next > NextW'(LimitScaled)) begin
              ovf_d = 1'b1;
            end else begin
              whole_d = WholeW'(whole_next);
            end
          end
        end
        default: err_d = ST_BAD_CHAR;
      endcase
    end

    tot_d.neg   = neg_d;
    tot_d.whole = whole_d;
    tot_d.frac  = WholeW'(frac_d);
    if (err_d != ST_OK) begin
      tot_d.status = err_d;
    end else if (cnt_d > CntW'(FRAC_DIGITS)) begin
      tot_d.status = ST_TOO_MANY_DEC;
    end else if (ovf_d) begin
      tot_d.status = ST_RANGE;
    end else begin
      tot_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q     <= 1'b0;
      dot_q     <= 1'b0;
      ovf_q     <= 1'b0;
      whole_q   <= '0;
      frac_q    <= '0;
      cnt_q     <= '0;
      err_q     <= ST_OK;
      tot_vld_q <= 1'b0;
    end else begin
      if (!tot_vld_q || out_ready_i) begin
        tot_vld_q <= tot_load;
      end
      if (pop) begin
        if (item_i.last) begin
          neg_q   <= 1'b0;
          dot_q   <= 1'b0;
          ovf_q   <= 1'b0;
          whole_q <= '0;
          frac_q  <= '0;
          cnt_q   <= '0;
          err_q   <= ST_OK;
        end else begin
          neg_q   <= neg_d;
          dot_q   <= dot_d;
          ovf_q   <= ovf_d;
          whole_q <= whole_d;
          frac_q  <= frac_d;
          cnt_q   <= cnt_d;
          err_q   <= err_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tot_load) begin
      tot_q <= tot_d;
    end
  end

endmodule

// File: design/dap_finish.sv
`timescale 1ns / 1ps
// Final stages: adds the two parts, checks the range and applies the sign.
module dap_finish (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dap_pkg::total_t               total_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [dap_pkg::AmountW-1:0] amount_o,
  output dap_pkg::status_e              status_o
);
  import dap_pkg::*;

  logic               sum_vld_q;
  logic [AmountW-1:0] mag_q;
  logic [AmountW-1:0] sum;
  status_e            sum_st_q;
  status_e            sum_st_d;
  logic               neg_q;
  logic               out_vld_q;
  logic [AmountW-1:0] amount_q;
  logic [AmountW-1:0] amount_d;
  status_e            status_q;
  logic               sum_ready;

  assign sum_ready   = !out_vld_q || out_ready_i;
  assign in_ready_o  = !sum_vld_q || sum_ready;
  assign out_valid_o = out_vld_q;
  assign amount_o    = amount_q;
  assign status_o    = status_q;

  assign sum = AmountW'(total_i.whole) + AmountW'(total_i.frac);

  always_comb begin
    if (total_i.status != ST_OK) begin
      sum_st_d = total_i.status;
    end else if (sum[AmountW-1]) begin
      sum_st_d = ST_RANGE;
    end else begin
      sum_st_d = ST_OK;
    end
    if (sum_st_q != ST_OK) begin
      amount_d = '0;
    end else if (neg_q) begin
      amount_d = '0 - mag_q;
    end else begin
      amount_d = mag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        sum_vld_q <= in_valid_i;
      end
      if (sum_ready) begin
        out_vld_q <= sum_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mag_q    <= sum;
      sum_st_q <= sum_st_d;
      neg_q    <= total_i.neg;
    end
    if (sum_vld_q && sum_ready) begin
      amount_q <= amount_d;
      status_q <= sum_st_q;
    end
  end

endmodule

// File: design/decimal_amount_parser.sv
`timescale 1ns / 1ps
// Top level of the decimal amount parser: front classifier, queue, accumulator and finish.
// The parser takes one ASCII character per input beat, with tlast on the final character
// of each amount, and returns one result beat per amount: the value in units of
// 10^-FRAC_DIGITS in tdata and a status code in tuser (0 ok, 1 bad character, 2 second dot,
// 3 too many decimals, 4 out of range), with tdata zero whenever the status is not ok.
// A leading plus or minus sign is optional, and empty whole or fraction parts count as zero.
// It sustains one character per clock cycle unless the input stalls under backpressure;
// a result passes the classifier register, queue, accumulator total and finish stages.
// Backpressure on the result side fills the two-entry queue before the input stalls.
module decimal_amount_parser #(
  parameter int unsigned FRAC_DIGITS = dap_pkg::FracDigitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [dap_pkg::ChW-1:0]            s_axis_tdata,  // [7:0] ch
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic signed [dap_pkg::AmountW-1:0] m_axis_tdata,  // [63:0] amount
  output logic [dap_pkg::StatusW-1:0]        m_axis_tuser   // [2:0] status
);
  import dap_pkg::*;

  logic    cls_valid;
  logic    cls_ready;
  item_t   cls_item;
  logic    q_valid;
  logic    q_ready;
  item_t   q_item;
  logic    tot_valid;
  logic    tot_ready;
  total_t  tot;
  status_e status;

  dap_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .ch_i        (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .out_valid_o (cls_valid),
    .out_ready_i (cls_ready),
    .item_o      (cls_item)
  );

  dap_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cls_valid),
    .in_ready_o  (cls_ready),
    .item_i      (cls_item),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .item_o      (q_item)
  );

  dap_accum #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .item_i      (q_item),
    .out_valid_o (tot_valid),
    .out_ready_i (tot_ready),
    .total_o     (tot)
  );

  dap_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tot_valid),
    .in_ready_o  (tot_ready),
    .total_i     (tot),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .amount_o    (m_axis_tdata),
    .status_o    (status)
  );

  assign m_axis_tuser = status;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("Nonzero amount with an error status.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= ST_RANGE))
    else $error("Undefined status code.");

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata != {1'b1, {(AmountW-1){1'b0}}}))
    else $error("Amount magnitude beyond the signed range.");

endmodule
